/* rtl/forth_data_stack_alu_assert.svh */
// ---------------------------------------------------------------------------
// forth_data_stack_alu_assert.svh
// Assertion macros used by the stack ALU top level.
// ---------------------------------------------------------------------------
`ifndef FORTH_DATA_STACK_ALU_ASSERT_SVH
`define FORTH_DATA_STACK_ALU_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define FDS_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define FDS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/fds_pkg.sv */
// ---------------------------------------------------------------------------
// fds_pkg
// Shared constants, command codes and controller/datapath interface types.
// ---------------------------------------------------------------------------
package fds_pkg;

	localparam int STACK_DEPTH = 256;
	localparam int SP_W = $clog2(STACK_DEPTH + 1);
	localparam int ADDR_W = $clog2(STACK_DEPTH);

	localparam logic [4:0] CMD_PUSH = 5'd0;
	localparam logic [4:0] CMD_ADD = 5'd1;
	localparam logic [4:0] CMD_SUB = 5'd2;
	localparam logic [4:0] CMD_MUL = 5'd3;
	localparam logic [4:0] CMD_DIV = 5'd4;
	localparam logic [4:0] CMD_MOD = 5'd5;
	localparam logic [4:0] CMD_NEG = 5'd6;
	localparam logic [4:0] CMD_ABS = 5'd7;
	localparam logic [4:0] CMD_MAX = 5'd8;
	localparam logic [4:0] CMD_MIN = 5'd9;
	localparam logic [4:0] CMD_AND = 5'd10;
	localparam logic [4:0] CMD_OR = 5'd11;
	localparam logic [4:0] CMD_XOR = 5'd12;
	localparam logic [4:0] CMD_EQ = 5'd13;
	localparam logic [4:0] CMD_GT = 5'd14;
	localparam logic [4:0] CMD_GE = 5'd15;
	localparam logic [4:0] CMD_LT = 5'd16;
	localparam logic [4:0] CMD_LE = 5'd17;
	localparam logic [4:0] CMD_PRINT = 5'd18;
	localparam logic [4:0] CMD_EMIT = 5'd19;
	localparam logic [4:0] CMD_CR = 5'd20;
	localparam logic [4:0] CMD_DROP = 5'd21;
	localparam logic [4:0] CMD_2DROP = 5'd22;
	localparam logic [4:0] CMD_DUP = 5'd23;
	localparam logic [4:0] CMD_NIP = 5'd24;
	localparam logic [4:0] CMD_SWAP = 5'd25;

	localparam logic [1:0] KIND_NONE = 2'd0;
	localparam logic [1:0] KIND_NUM = 2'd1;
	localparam logic [1:0] KIND_CHAR = 2'd2;
	localparam logic [1:0] KIND_CR = 2'd3;

	localparam logic [1:0] ERR_OK = 2'd0;
	localparam logic [1:0] ERR_UNDER = 2'd1;
	localparam logic [1:0] ERR_OVER = 2'd2;
	localparam logic [1:0] ERR_DIVZ = 2'd3;

	// Controller to datapath commands
	typedef struct packed {
		logic load;      // capture command/literal, start operand reads
		logic read2;     // second operand read cycle
		logic div_start; // launch divider
		logic commit;    // write back and build result
	} ctl_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic is_div;    // current op uses divider (no error)
		logic div_done;
	} dp_stat_t;

endpackage

/* rtl/forth_data_stack_alu.sv */
// Sequence: accept, read operands, commit; div and mod add a pass through the
// one-bit-per-cycle divider. A new primitive is accepted only after the last one
// is committed. Operands come from one memory read port, one a cycle.
// Reset: arst_n clears the stack pointer and control; stack memory is not cleared.
// ---------------------------------------------------------------------------
// forth_data_stack_alu
// Forth data stack with ALU: one primitive per accepted beat, one result beat.
// ---------------------------------------------------------------------------
`include "forth_data_stack_alu_assert.svh"

module forth_data_stack_alu (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [4:0]         command,
	input  logic signed [31:0] literal,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         out_kind,
	output logic signed [31:0] out_value,
	output logic [1:0]         error,
	output logic [8:0]         depth
);

	fds_pkg::ctl_cmd_t cmd;
	fds_pkg::dp_stat_t stat;
	logic [fds_pkg::SP_W-1:0] sp;

	fds_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready), .stat(stat), .cmd(cmd)
	);

	fds_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat),
		.command(command), .literal(literal), .out_kind(out_kind),
		.out_value(out_value), .error(error), .depth(depth), .sp_o(sp)
	);

	// Checks
	`FDS_ASSERT_IMP(a_sp_range, 1'b1, sp <= fds_pkg::SP_W'(fds_pkg::STACK_DEPTH), "sp beyond depth")
	`FDS_ASSERT_IMP(a_err_quiet, out_valid && error != fds_pkg::ERR_OK, out_kind == fds_pkg::KIND_NONE, "output on error")
	`FDS_ASSERT_NEXT(a_commit_valid, cmd.commit, out_valid, "commit without result")
	`FDS_ASSERT_IMP(a_no_overlap, cmd.load, !cmd.commit, "load during commit")

endmodule

/* rtl/fds_divider.sv */
// ---------------------------------------------------------------------------
// fds_divider
// Radix-2 restoring signed divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module fds_divider (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] num,
	input  logic [31:0] den,
	output logic        done,
	output logic [31:0] quo,
	output logic [31:0] rem
);

	logic [31:0] q_q;
	logic [32:0] r_q;
	logic [31:0] d_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic        nn_q;
	logic        dn_q;
	logic [32:0] trial;
	logic [32:0] shifted;

	assign shifted = {r_q[31:0], q_q[31]};
	assign trial = shifted - {1'b0, d_q};

	// Iterate one bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= 6'd0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= 6'd32;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	// Datapath of the iteration
	always_ff @(posedge clk) begin
		if (start) begin
			nn_q <= num[31];
			dn_q <= den[31];
			q_q <= num[31] ? (32'd0 - num) : num;
			d_q <= den[31] ? (32'd0 - den) : den;
			r_q <= 33'd0;
		end else if (busy_q) begin
			if (!trial[32]) begin
				r_q <= trial;
				q_q <= {q_q[30:0], 1'b1};
			end else begin
				r_q <= shifted;
				q_q <= {q_q[30:0], 1'b0};
			end
		end
	end

	assign quo = (nn_q != dn_q) ? (32'd0 - q_q) : q_q;
	assign rem = nn_q ? (32'd0 - r_q[31:0]) : r_q[31:0];

endmodule

/* rtl/fds_ctrl.sv */
// ---------------------------------------------------------------------------
// fds_ctrl
// Sequencer: accept, read operands, optional divide, commit, deliver.
// ---------------------------------------------------------------------------
module fds_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  logic                 out_ready,
	input  fds_pkg::dp_stat_t    stat,
	output fds_pkg::ctl_cmd_t    cmd
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_RD2 = 3'd1;
	localparam logic [2:0] ST_EXEC = 3'd2;
	localparam logic [2:0] ST_DIV = 3'd3;
	localparam logic [2:0] ST_OUT = 3'd4;

	logic [2:0] state_q;
	logic       out_free;

	// Output register is free when empty or being drained
	assign out_free = !out_valid || out_ready;
	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		cmd = '0;
		cmd.load = in_valid && in_ready;
		cmd.read2 = (state_q == ST_RD2);
		cmd.div_start = (state_q == ST_EXEC) && stat.is_div;
		cmd.commit = ((state_q == ST_EXEC) && !stat.is_div && out_free) ||
			((state_q == ST_OUT) && out_free);
	end

	// Advance the sequence
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid <= 1'b0;
		end else begin
			if (out_valid && out_ready) out_valid <= 1'b0;
			if (cmd.commit) out_valid <= 1'b1;
			case (state_q)
				ST_IDLE: if (cmd.load) state_q <= ST_RD2;
				ST_RD2: state_q <= ST_EXEC;
				ST_EXEC: begin
					if (stat.is_div) state_q <= ST_DIV;
					else if (out_free) state_q <= ST_IDLE;
				end
				ST_DIV: if (stat.div_done) state_q <= ST_OUT;
				ST_OUT: if (out_free) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

/* rtl/fds_datapath.sv */
// ---------------------------------------------------------------------------
// fds_datapath
// Stack memory, stack pointer, ALU, divider and result register.
// ---------------------------------------------------------------------------
module fds_datapath (
	input  logic                         clk,
	input  logic                         arst_n,
	input  fds_pkg::ctl_cmd_t            cmd,
	output fds_pkg::dp_stat_t            stat,
	input  logic [4:0]                   command,
	input  logic signed [31:0]           literal,
	output logic [1:0]                   out_kind,
	output logic signed [31:0]           out_value,
	output logic [1:0]                   error,
	output logic [8:0]                   depth,
	output logic [fds_pkg::SP_W-1:0]     sp_o
);

	logic [31:0] mem_q [fds_pkg::STACK_DEPTH];
	logic [31:0] rd_q;
	logic [31:0] a_q;
	logic [31:0] b_q;
	logic [4:0]  cmd_q;
	logic [31:0] lit_q;
	logic [fds_pkg::SP_W-1:0] sp_q;
	logic [fds_pkg::ADDR_W-1:0] rd_addr;
	logic [1:0]  need;
	logic [1:0]  err_c;
	logic        binop;
	logic        slt_ba;
	logic        slt_ab;
	logic [31:0] res;
	logic        div_done;
	logic [31:0] quo;
	logic [31:0] rem;
	logic        we;
	logic [fds_pkg::ADDR_W-1:0] wa;
	logic [31:0] wd;
	logic        we2;
	logic [fds_pkg::ADDR_W-1:0] wa2;
	logic [31:0] wd2;
	logic [fds_pkg::SP_W-1:0] sp_n;

	localparam logic [fds_pkg::SP_W-1:0] SP_FULL = fds_pkg::SP_W'(fds_pkg::STACK_DEPTH);

	// Read top at load, next at read2
	assign rd_addr = cmd.load ? fds_pkg::ADDR_W'(sp_q - 1'b1)
		: fds_pkg::ADDR_W'(sp_q - 2'd2);

	always_ff @(posedge clk) begin
		if (cmd.load || cmd.read2) rd_q <= mem_q[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q <= command;
			lit_q <= literal;
		end
		if (cmd.read2) a_q <= rd_q;
	end
	assign b_q = rd_q;

	// Operand count and error check
	always_comb begin
		need = 2'd0;
		binop = 1'b0;
		if (cmd_q >= fds_pkg::CMD_ADD && cmd_q <= fds_pkg::CMD_LE) begin
			if (cmd_q == fds_pkg::CMD_NEG || cmd_q == fds_pkg::CMD_ABS) need = 2'd1;
			else begin
				need = 2'd2;
				binop = 1'b1;
			end
		end else if (cmd_q == fds_pkg::CMD_PRINT || cmd_q == fds_pkg::CMD_EMIT ||
			cmd_q == fds_pkg::CMD_DROP || cmd_q == fds_pkg::CMD_DUP) need = 2'd1;
		else if (cmd_q == fds_pkg::CMD_2DROP || cmd_q == fds_pkg::CMD_NIP ||
			cmd_q == fds_pkg::CMD_SWAP) need = 2'd2;
		err_c = fds_pkg::ERR_OK;
		if (sp_q < fds_pkg::SP_W'(need)) err_c = fds_pkg::ERR_UNDER;
		else if ((cmd_q == fds_pkg::CMD_PUSH || cmd_q == fds_pkg::CMD_DUP) && sp_q >= SP_FULL)
			err_c = fds_pkg::ERR_OVER;
		else if ((cmd_q == fds_pkg::CMD_DIV || cmd_q == fds_pkg::CMD_MOD) && a_q == 32'd0)
			err_c = fds_pkg::ERR_DIVZ;
	end

	assign stat.is_div = (err_c == fds_pkg::ERR_OK) &&
		(cmd_q == fds_pkg::CMD_DIV || cmd_q == fds_pkg::CMD_MOD);
	assign stat.div_done = div_done;

	fds_divider u_div (
		.clk(clk), .arst_n(arst_n), .start(cmd.div_start),
		.num(b_q), .den(a_q), .done(div_done), .quo(quo), .rem(rem)
	);

	assign slt_ba = $signed(b_q) < $signed(a_q);
	assign slt_ab = $signed(a_q) < $signed(b_q);

	// Binary ALU result
	always_comb begin
		case (cmd_q)
			fds_pkg::CMD_ADD: res = b_q + a_q;
			fds_pkg::CMD_SUB: res = b_q - a_q;
			fds_pkg::CMD_MUL: res = b_q * a_q;
			fds_pkg::CMD_DIV: res = quo;
			fds_pkg::CMD_MOD: res = rem;
			fds_pkg::CMD_MAX: res = slt_ba ? a_q : b_q;
			fds_pkg::CMD_MIN: res = slt_ab ? a_q : b_q;
			fds_pkg::CMD_AND: res = a_q & b_q;
			fds_pkg::CMD_OR: res = a_q | b_q;
			fds_pkg::CMD_XOR: res = a_q ^ b_q;
			fds_pkg::CMD_EQ: res = {31'd0, a_q == b_q};
			fds_pkg::CMD_GT: res = {31'd0, slt_ab};
			fds_pkg::CMD_GE: res = {31'd0, !slt_ba};
			fds_pkg::CMD_LT: res = {31'd0, slt_ba};
			default: res = {31'd0, !slt_ab};
		endcase
	end

	// Write-back plan
	always_comb begin
		we = 1'b0; wa = fds_pkg::ADDR_W'(sp_q - 1'b1); wd = a_q;
		we2 = 1'b0; wa2 = fds_pkg::ADDR_W'(sp_q - 2'd2); wd2 = a_q;
		sp_n = sp_q;
		if (err_c == fds_pkg::ERR_OK) begin
			if (binop) begin
				we = 1'b1; wa = fds_pkg::ADDR_W'(sp_q - 2'd2); wd = res;
				sp_n = sp_q - 1'b1;
			end else begin
				case (cmd_q)
					fds_pkg::CMD_PUSH: begin
						we = 1'b1; wa = fds_pkg::ADDR_W'(sp_q); wd = lit_q;
						sp_n = sp_q + 1'b1;
					end
					fds_pkg::CMD_NEG: begin we = 1'b1; wd = 32'd0 - a_q; end
					fds_pkg::CMD_ABS: begin we = a_q[31]; wd = 32'd0 - a_q; end
					fds_pkg::CMD_PRINT, fds_pkg::CMD_DROP: sp_n = sp_q - 1'b1;
					fds_pkg::CMD_2DROP: sp_n = sp_q - 2'd2;
					fds_pkg::CMD_DUP: begin
						we = 1'b1; wa = fds_pkg::ADDR_W'(sp_q); sp_n = sp_q + 1'b1;
					end
					fds_pkg::CMD_NIP: begin
						we = 1'b1; wa = fds_pkg::ADDR_W'(sp_q - 2'd2);
						sp_n = sp_q - 1'b1;
					end
					fds_pkg::CMD_SWAP: begin
						we = 1'b1; wd = b_q; we2 = 1'b1;
					end
					default: sp_n = sp_q;
				endcase
			end
		end
	end

	// Commit into memory (swap uses two writes on distinct entries)
	always_ff @(posedge clk) begin
		if (cmd.commit && we) mem_q[wa] <= wd;
		if (cmd.commit && we2) mem_q[wa2] <= wd2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) sp_q <= '0;
		else if (cmd.commit) sp_q <= sp_n;
	end

	// Result register
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			error <= err_c;
			depth <= 9'(sp_n);
			out_kind <= fds_pkg::KIND_NONE;
			out_value <= '0;
			if (err_c == fds_pkg::ERR_OK) begin
				case (cmd_q)
					fds_pkg::CMD_PRINT: begin
						out_kind <= fds_pkg::KIND_NUM; out_value <= a_q;
					end
					fds_pkg::CMD_EMIT: begin
						out_kind <= fds_pkg::KIND_CHAR; out_value <= {24'd0, a_q[7:0]};
					end
					fds_pkg::CMD_CR: out_kind <= fds_pkg::KIND_CR;
					default: out_kind <= fds_pkg::KIND_NONE;
				endcase
			end
		end
	end

	assign sp_o = sp_q;

endmodule

/* tb/forth_data_stack_alu_tb.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// forth_data_stack_alu_tb
// Drives Forth primitives into the data stack ALU with random sender bursts
// and receiver stalls, predicts every result beat and checks it field by field.
// ---------------------------------------------------------------------------
module forth_data_stack_alu_tb;

	localparam logic [4:0] CMD_NOP = 5'd26;
	localparam int N_RANDOM = 550;

	typedef struct {
		logic [1:0]  kind;
		logic [31:0] value;
		logic [1:0]  err;
		logic [8:0]  dep;
	} step_res_t;

	typedef struct {
		logic [4:0]  cmd;
		logic [31:0] lit;
		bit          typed;
		step_res_t   res;
	} dir_row_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic [4:0]         command;
	logic signed [31:0] literal;
	logic               out_valid;
	logic               out_ready;
	logic [1:0]         out_kind;
	logic signed [31:0] out_value;
	logic [1:0]         error;
	logic [8:0]         depth;

	// stack copy for prediction
	logic [31:0] stk [fds_pkg::STACK_DEPTH];
	int          sp;
	step_res_t   pending [$];
	int          n_fail;
	int          n_got;

	forth_data_stack_alu u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.command(command), .literal(literal),
		.out_valid(out_valid), .out_ready(out_ready),
		.out_kind(out_kind), .out_value(out_value),
		.error(error), .depth(depth)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	function automatic bit lt_s(logic [31:0] x, logic [31:0] y);
		return $signed(x) < $signed(y);
	endfunction

	// execute one primitive on the stack copy
	function automatic step_res_t exec_primitive(logic [4:0] cmd, logic [31:0] lit);
		step_res_t   r;
		int          need;
		logic [31:0] a, b, res, mn, md, mq, mr;
		r = '{fds_pkg::KIND_NONE, 32'd0, fds_pkg::ERR_OK, 9'd0};
		need = 0;
		a = 0;
		b = 0;
		res = 0;
		if (cmd >= fds_pkg::CMD_ADD && cmd <= fds_pkg::CMD_LE)
			need = (cmd == fds_pkg::CMD_NEG || cmd == fds_pkg::CMD_ABS) ? 1 : 2;
		else if (cmd == fds_pkg::CMD_PRINT || cmd == fds_pkg::CMD_EMIT ||
				cmd == fds_pkg::CMD_DROP || cmd == fds_pkg::CMD_DUP)
			need = 1;
		else if (cmd == fds_pkg::CMD_2DROP || cmd == fds_pkg::CMD_NIP ||
				cmd == fds_pkg::CMD_SWAP)
			need = 2;
		if (sp < need) begin
			r.err = fds_pkg::ERR_UNDER;
		end else if ((cmd == fds_pkg::CMD_PUSH || cmd == fds_pkg::CMD_DUP) &&
				sp >= fds_pkg::STACK_DEPTH) begin
			r.err = fds_pkg::ERR_OVER;
		end else begin
			if (need >= 1) a = stk[sp-1];
			if (need >= 2) b = stk[sp-2];
			if ((cmd == fds_pkg::CMD_DIV || cmd == fds_pkg::CMD_MOD) && a == 0) begin
				r.err = fds_pkg::ERR_DIVZ;
			end else if (need == 2 && cmd <= fds_pkg::CMD_LE) begin
				mn = b[31] ? -b : b;
				md = a[31] ? -a : a;
				mq = (md != 0) ? mn / md : 0;
				mr = (md != 0) ? mn % md : 0;
				case (cmd)
					fds_pkg::CMD_ADD: res = b + a;
					fds_pkg::CMD_SUB: res = b - a;
					fds_pkg::CMD_MUL: res = b * a;
					fds_pkg::CMD_DIV: res = (b[31] != a[31]) ? -mq : mq;
					fds_pkg::CMD_MOD: res = b[31] ? -mr : mr;
					fds_pkg::CMD_MAX: res = lt_s(b, a) ? a : b;
					fds_pkg::CMD_MIN: res = lt_s(a, b) ? a : b;
					fds_pkg::CMD_AND: res = a & b;
					fds_pkg::CMD_OR:  res = a | b;
					fds_pkg::CMD_XOR: res = a ^ b;
					fds_pkg::CMD_EQ:  res = {31'd0, a == b};
					fds_pkg::CMD_GT:  res = {31'd0, lt_s(a, b)};
					fds_pkg::CMD_GE:  res = {31'd0, !lt_s(b, a)};
					fds_pkg::CMD_LT:  res = {31'd0, lt_s(b, a)};
					default: res = {31'd0, !lt_s(a, b)};
				endcase
				sp--;
				stk[sp-1] = res;
			end else begin
				case (cmd)
					fds_pkg::CMD_PUSH: begin
						stk[sp] = lit;
						sp++;
					end
					fds_pkg::CMD_NEG: stk[sp-1] = -a;
					fds_pkg::CMD_ABS: if (a[31]) stk[sp-1] = -a;
					fds_pkg::CMD_PRINT: begin
						r.kind = fds_pkg::KIND_NUM;
						r.value = a;
						sp--;
					end
					fds_pkg::CMD_EMIT: begin
						r.kind = fds_pkg::KIND_CHAR;
						r.value = {24'd0, a[7:0]};
					end
					fds_pkg::CMD_CR: r.kind = fds_pkg::KIND_CR;
					fds_pkg::CMD_DROP: sp--;
					fds_pkg::CMD_2DROP: sp -= 2;
					fds_pkg::CMD_DUP: begin
						stk[sp] = a;
						sp++;
					end
					fds_pkg::CMD_NIP: begin
						sp--;
						stk[sp-1] = a;
					end
					fds_pkg::CMD_SWAP: begin
						stk[sp-1] = b;
						stk[sp-2] = a;
					end
					default: ;
				endcase
			end
		end
		r.dep = sp[8:0];
		return r;
	endfunction

	// send one beat, idling in random bursts
	int burst_left;
	task automatic send_beat(logic [4:0] cmd, logic [31:0] lit);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 20);
			if ($urandom_range(0, 2) != 0) repeat ($urandom_range(1, 6)) @(negedge clk);
		end
		burst_left--;
		in_valid = 1'b1;
		command = cmd;
		literal = lit;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		pending.push_back(exec_primitive(cmd, lit));
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	// pick an operand with bias toward edge values
	function automatic logic [31:0] pick_val();
		case ($urandom_range(0, 7))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'hffff_ffff;
			3: return 32'd0;
			4: return $urandom_range(0, 9);
			default: return $urandom;
		endcase
	endfunction

	// check result beats against the oldest prediction
	always @(posedge clk) begin
		step_res_t e;
		if (arst_n && out_valid && out_ready) begin
			n_got++;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result beat kind=%0d value=%0d err=%0d depth=%0d",
					$time, out_kind, out_value, error, depth);
				n_fail++;
			end else begin
				e = pending.pop_front();
				if (out_kind !== e.kind || out_value !== e.value ||
						error !== e.err || depth !== e.dep) begin
					$display("%0t: mismatch expected kind=%0d value=%0h err=%0d depth=%0d",
						$time, e.kind, e.value, e.err, e.dep);
					$display("%0t:          actual   kind=%0d value=%0h err=%0d depth=%0d",
						$time, out_kind, out_value, error, depth);
					n_fail++;
				end
			end
		end
	end

	// receiver stall pattern
	int stall_ph;
	always @(negedge clk) begin
		stall_ph <= stall_ph + 1;
		if (stall_ph % 512 < 128) out_ready <= 1'b1;
		else out_ready <= ($urandom_range(0, 3) != 0) && (stall_ph % 7 != 3);
	end

	// stop a hung run
	initial begin
		#20ms;
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		dir_row_t    rows [$];
		step_res_t   got;
		logic [4:0]  c;
		int          k, wait_cyc;
		in_valid = 1'b0;
		command = CMD_NOP;
		literal = 0;
		out_ready = 1'b0;
		stall_ph = 0;
		arst_n = 1'b0;
		sp = 0;
		n_fail = 0;
		n_got = 0;
		burst_left = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed rows; typed results only where obvious
		rows.push_back('{fds_pkg::CMD_DROP, 0, 1,
			'{fds_pkg::KIND_NONE, 0, fds_pkg::ERR_UNDER, 9'd0}});
		rows.push_back('{fds_pkg::CMD_CR, 0, 1,
			'{fds_pkg::KIND_CR, 0, fds_pkg::ERR_OK, 9'd0}});
		rows.push_back('{fds_pkg::CMD_PUSH, 32'h8000_0000, 1,
			'{fds_pkg::KIND_NONE, 0, fds_pkg::ERR_OK, 9'd1}});
		rows.push_back('{fds_pkg::CMD_ADD, 0, 1,
			'{fds_pkg::KIND_NONE, 0, fds_pkg::ERR_UNDER, 9'd1}});
		rows.push_back('{fds_pkg::CMD_PUSH, 32'hffff_ffff, 1,
			'{fds_pkg::KIND_NONE, 0, fds_pkg::ERR_OK, 9'd2}});
		rows.push_back('{fds_pkg::CMD_DIV, 0, 0, '{default: 0}});
		rows.push_back('{fds_pkg::CMD_PUSH, 32'h8000_0000, 0, '{default: 0}});
		rows.push_back('{fds_pkg::CMD_PUSH, 32'hffff_ffff, 0, '{default: 0}});
		rows.push_back('{fds_pkg::CMD_MOD, 0, 0, '{default: 0}});
		rows.push_back('{fds_pkg::CMD_PUSH, 0, 0, '{default: 0}});
		rows.push_back('{fds_pkg::CMD_DIV, 0, 1,
			'{fds_pkg::KIND_NONE, 0, fds_pkg::ERR_DIVZ, 9'd3}});
		rows.push_back('{fds_pkg::CMD_MOD, 0, 1,
			'{fds_pkg::KIND_NONE, 0, fds_pkg::ERR_DIVZ, 9'd3}});
		rows.push_back('{fds_pkg::CMD_PUSH, 32'h7fff_ffff, 0, '{default: 0}});
		rows.push_back('{fds_pkg::CMD_EMIT, 0, 1,
			'{fds_pkg::KIND_CHAR, 32'hff, fds_pkg::ERR_OK, 9'd4}});
		rows.push_back('{fds_pkg::CMD_NEG, 0, 0, '{default: 0}});
		rows.push_back('{fds_pkg::CMD_ABS, 0, 0, '{default: 0}});
		rows.push_back('{fds_pkg::CMD_SWAP, 0, 0, '{default: 0}});
		rows.push_back('{fds_pkg::CMD_NIP, 0, 0, '{default: 0}});
		rows.push_back('{fds_pkg::CMD_DUP, 0, 0, '{default: 0}});
		rows.push_back('{fds_pkg::CMD_PRINT, 0, 0, '{default: 0}});
		rows.push_back('{fds_pkg::CMD_2DROP, 0, 0, '{default: 0}});
		rows.push_back('{5'd31, 32'h1234_5678, 0, '{default: 0}});
		for (int i = 0; i < rows.size(); i++) begin
			send_beat(rows[i].cmd, rows[i].lit);
			if (rows[i].typed) begin
				got = pending[pending.size()-1];
				if (got.kind !== rows[i].res.kind || got.value !== rows[i].res.value ||
						got.err !== rows[i].res.err || got.dep !== rows[i].res.dep) begin
					$display("%0t: row %0d expected err=%0d depth=%0d, predicted err=%0d depth=%0d",
						$time, i, rows[i].res.err, rows[i].res.dep, got.err, got.dep);
					n_fail++;
				end
			end
		end

		// fill to full, test overflow on push and dup, then drain
		while (sp < fds_pkg::STACK_DEPTH) send_beat(fds_pkg::CMD_PUSH, $urandom);
		send_beat(fds_pkg::CMD_PUSH, 32'h5555_aaaa);
		send_beat(fds_pkg::CMD_DUP, 0);
		send_beat(fds_pkg::CMD_ADD, 0);
		send_beat(fds_pkg::CMD_DUP, 0);
		while (sp > 1) send_beat(fds_pkg::CMD_2DROP, 0);

		// hold off until every result is back
		wait_cyc = 0;
		while (pending.size() != 0) @(negedge clk);

		// random phase: mostly short binary sequences, some noise
		for (int n = 0; n < N_RANDOM; n++) begin
			k = $urandom_range(0, 9);
			if (k < 3 && sp < fds_pkg::STACK_DEPTH) begin
				send_beat(fds_pkg::CMD_PUSH, pick_val());
			end else if (k < 8) begin
				c = 5'($urandom_range(1, 25));
				if (sp < 2 && $urandom_range(0, 3) != 0) send_beat(fds_pkg::CMD_PUSH, pick_val());
				else send_beat(c, $urandom);
			end else begin
				send_beat(5'($urandom_range(0, 31)), $urandom);
			end
			if (sp > 12 && $urandom_range(0, 1) == 0) send_beat(fds_pkg::CMD_DROP, 0);
		end

		// drain with a timeout, then idle before the final verdict
		while (pending.size() != 0 && wait_cyc < 200000) begin
			@(negedge clk);
			wait_cyc++;
		end
		repeat (60) @(posedge clk);
		if (n_fail == 0 && pending.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

/* forth_data_stack_alu.f */
+incdir+rtl
rtl/fds_pkg.sv
rtl/fds_divider.sv
rtl/fds_ctrl.sv
rtl/fds_datapath.sv
rtl/forth_data_stack_alu.sv
tb/forth_data_stack_alu_tb.sv
